>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define KAS_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("%m: check failed");
`define KAS_IMPLY(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: check failed");
`else
`define KAS_ASSERT(lbl, clk, rstn, expr)
`define KAS_IMPLY(lbl, clk, rstn, ante, cons)
`endif
`endif

>>> rtl/kas_pkg.sv
// ----------------------------------------------------------------------------
// kas_pkg
// Types, constants and the arctangent table of the Kepler anomaly solver.
// ----------------------------------------------------------------------------
package kas_pkg;

    typedef enum logic [4:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_ANGLES,
        S_SC_INIT,
        S_CORDIC,
        S_SC_MAP,
        S_N_MES,
        S_N_MEC,
        S_N_P00,
        S_N_P01,
        S_N_P10,
        S_N_P11,
        S_N_F,
        S_N_UPD,
        S_F_MEC,
        S_F_DEN,
        S_F_RAD,
        S_F_RADS,
        S_SQRT,
        S_F_YQ,
        S_F_VEC,
        S_DONE
    } t_state;

    typedef logic [63:0][63:0] t_atan_lut;

    localparam logic [63:0] Q62_ONE     = 64'h4000_0000_0000_0000;
    localparam logic [63:0] TURN_MASK   = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] HALF_TURN   = 64'h2000_0000_0000_0000;
    localparam logic [63:0] EIGHTH_TURN = 64'h0800_0000_0000_0000;
    localparam logic [63:0] INV_TWO_PI  = 64'h28BE_60DB_9391_054A;
    localparam logic signed [63:0] CORDIC_GAIN = 64'sd2800459870029452965;
    localparam logic signed [63:0] DEN_ONE     = 64'sh1000_0000_0000_0000;
    localparam logic [63:0] SQRT_BIT0   = 64'h4000_0000_0000_0000;
    localparam logic [63:0] SQRT_UNITY  = 64'h0000_0001_0000_0000;

    localparam int CFG_W = 16;
    localparam logic CFG_TOLERANCE = 1'b0;
    localparam logic CFG_MAX_ITER  = 1'b1;

    localparam logic [15:0] TOL_RESET   = 16'd16;
    localparam logic [6:0]  ITER_RESET  = 7'd16;
    localparam logic [6:0]  ITER_CAP    = 7'd64;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOCONV = 2'd1;
    localparam logic [1:0] STAT_ZDIV   = 2'd2;
    localparam logic [1:0] STAT_SAT    = 2'd3;

    // long division by bit steps, elaboration only
    function automatic logic [63:0] udiv_const(input logic [63:0] num,
                                               input logic [63:0] den);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], num[b]};
            quo = {quo[62:0], 1'b0};
            if (rem >= den) begin
                rem    = rem - den;
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    // atan(2^-i) in Q62 turns from the odd power series
    function automatic t_atan_lut atan_lut_f();
        t_atan_lut   lut;
        logic [63:0] sum;
        logic [63:0] term;
        logic [127:0] prod;
        int          sh;
        lut    = '0;
        lut[0] = EIGHTH_TURN;
        for (int i = 1; i < 64; i++) begin
            sum = '0;
            for (int k = 0; k < 32; k++) begin
                sh = i * (2 * k + 1);
                if (sh <= 62) begin
                    term = udiv_const(64'd1 << (62 - sh), 64'(2 * k + 1));
                    if ((k & 1) != 0) sum = sum - term;
                    else sum = sum + term;
                end
            end
            prod   = {64'd0, sum} * {64'd0, INV_TWO_PI};
            lut[i] = prod[127:64];
        end
        return lut;
    endfunction

endpackage

>>> rtl/kepler_anomaly_solver.sv
// ----------------------------------------------------------------------------
// kepler_anomaly_solver
// Perturbs orbital elements and solves Kepler's equation by Newton iteration
// on one shared CORDIC, multiplier, divider and square-root sequencer.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                  payload
//  config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//  input     in         i_in_valid / o_in_ready    orbit elements, perturbations
//  output    out        o_out_valid / i_out_ready  anomalies, radius, status
//
//  One item at a time. Each Newton step is one CORDIC rotation, the
//  multiplier states S_N_MES to S_N_P11 and, unless the quotient would
//  overflow, a bit-serial divide.
//  Synchronous active-low reset; tolerance 16, max_iterations 16, seed 0.
//  A finished result waits in the output register; a stalled output holds
//  the sequencer only when the next result is ready to be written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kepler_anomaly_solver
    import kas_pkg::*;
#(
    parameter int ANGLE_BITS    = 32,
    parameter int CORDIC_STAGES = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [31:0]         i_mean_longitude,
    input  logic [31:0]         i_perihelion_longitude,
    input  logic [31:0]         i_node_longitude,
    input  logic [31:0]         i_semi_major_axis,
    input  logic [31:0]         i_eccentricity,
    input  logic signed [31:0]  i_axis_pert,
    input  logic signed [31:0]  i_ecc_pert,
    input  logic signed [31:0]  i_longitude_pert,
    input  logic signed [31:0]  i_perihelion_pert,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [31:0]         o_mean_anomaly,
    output logic [31:0]         o_arg_perihelion,
    output logic [31:0]         o_ecc_anomaly,
    output logic [31:0]         o_radius,
    output logic [31:0]         o_true_anomaly,
    output logic [31:0]         o_ecc_perturbed,
    output logic [31:0]         o_axis_perturbed,
    output logic [1:0]          o_status
);

    localparam logic [63:0] LOW_MASK   = (64'd1 << (62 - ANGLE_BITS)) - 64'd1;
    localparam logic [63:0] AMASK      = TURN_MASK & ~LOW_MASK;
    localparam t_atan_lut   ATAN_LUT   = atan_lut_f();
    localparam logic [5:0]  LAST_STAGE = 6'(CORDIC_STAGES - 1);

    t_state r_state, n_state;

    // control
    logic        r_out_valid;
    logic [15:0] r_tol;
    logic [6:0]  r_max_iter;
    logic [31:0] r_last_ea;
    logic [6:0]  r_iter;
    logic [6:0]  r_iter_max;
    logic [5:0]  r_stage;

    // item payload
    logic [31:0] r_lon, r_wb, r_node, r_na, r_e, r_e0, r_vk, r_m, r_w, r_radius;
    logic        r_sat, r_zdiv, r_conv, r_final, r_corr_phase, r_vec, r_fpos;
    logic [63:0] r_ea;

    // shared units
    logic signed [63:0] r_x, r_y, r_z, r_c, r_s, r_es;
    logic [1:0]         r_quad;
    logic signed [67:0] r_prod;
    logic [63:0]        r_den, r_rem, r_lo, r_quo;
    logic [5:0]         r_dcnt;
    logic [33:0]        r_mid;
    logic [32:0]        r_acc;
    logic [63:0]        r_sq_n, r_sq_res, r_sq_bit;

    // output register
    logic [31:0] r_mean_anomaly, r_arg_perihelion, r_ecc_anomaly, r_radius_out;
    logic [31:0] r_true_anomaly, r_ecc_perturbed, r_axis_perturbed;
    logic [1:0]  r_status;

    logic signed [33:0] op_a, op_b;
    logic signed [67:0] mul_p;
    logic               in_acc, done_load, div_ovf;

    logic [6:0]  iters;
    logic signed [33:0] na_sum, ne_sum;
    logic [31:0] na_sat, ne_sat;
    logic        na_flag, ne_flag;
    logic signed [31:0] c30, s30;
    logic [63:0] esm;

    logic signed [63:0] cx_dx, cx_dy, cx_t;
    logic               cx_dir;

    logic [31:0] corr32, wb_new, mag;
    logic signed [63:0] ec, den_raw;
    logic [63:0] den_clamp;
    logic [63:0] d_ang, est, fm;
    logic signed [63:0] ds, f;
    logic [63:0] rem_sh;
    logic [63:0] ea_new;
    logic        conv_now;
    logic [63:0] sc_a, sc_sum, sc_r;
    logic [1:0]  sc_q;
    logic [63:0] sq_try;
    logic signed [63:0] xq, yq, xi, yi;
    logic [37:0] prod_radius;

    assign in_acc    = i_in_valid && o_in_ready;
    assign done_load = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign iters = (r_max_iter == 7'd0) ? 7'd1 :
                   ((r_max_iter > ITER_CAP) ? ITER_CAP : r_max_iter);

    // element perturbation with saturation to the unsigned 32-bit range
    assign na_sum  = $signed({2'b00, i_semi_major_axis}) +
                     $signed({{2{i_axis_pert[31]}}, i_axis_pert});
    assign ne_sum  = $signed({2'b00, i_eccentricity}) +
                     $signed({{2{i_ecc_pert[31]}}, i_ecc_pert});
    assign na_flag = na_sum[33] || na_sum[32];
    assign ne_flag = ne_sum[33] || ne_sum[32];
    assign na_sat  = na_sum[33] ? 32'd0 : (na_sum[32] ? 32'hFFFF_FFFF : na_sum[31:0]);
    assign ne_sat  = ne_sum[33] ? 32'd0 : (ne_sum[32] ? 32'hFFFF_FFFF : ne_sum[31:0]);

    assign c30 = r_c[63:32];
    assign s30 = r_s[63:32];
    assign esm = r_es[63] ? (64'd0 - r_es) : r_es;
    assign mag = r_vk[31] ? (32'd0 - r_vk) : r_vk;

    assign mul_p = op_a * op_b;

    // CORDIC micro-rotation, rotation or vectoring
    assign cx_dx  = r_y >>> r_stage;
    assign cx_dy  = r_x >>> r_stage;
    assign cx_t   = $signed(ATAN_LUT[r_stage]);
    assign cx_dir = r_vec ? r_y[63] : !r_z[63];

    // 1 - e cos E in Q60, floored at one lsb
    assign ec        = $signed(r_prod[63:0]);
    assign den_raw   = DEN_ONE - (ec >>> 2);
    assign den_clamp = (den_raw < 64'sd1) ? 64'd1 : den_raw;

    assign corr32 = (r_zdiv || !r_vk[31]) ? r_quo[31:0] : (32'd0 - r_quo[31:0]);
    assign wb_new = r_wb + corr32;

    // Kepler residual
    assign est   = r_prod[63:0] + {31'd0, r_acc} + {62'd0, r_mid[33:32]};
    assign d_ang = (r_ea - {2'b00, r_m, 30'd0}) & TURN_MASK;
    assign ds    = d_ang[61] ? $signed(d_ang - Q62_ONE) : $signed(d_ang);
    assign f     = r_es[63] ? (ds + $signed(est)) : (ds - $signed(est));
    assign fm    = f[63] ? (64'd0 - f) : f;
    assign div_ovf = ({4'd0, fm[63:4]} >= r_den);

    assign rem_sh = {r_rem[62:0], r_lo[63]};

    assign ea_new   = (r_fpos ? (r_ea - r_quo) : (r_ea + r_quo)) & AMASK;
    assign conv_now = (r_quo <= {18'd0, r_tol, 30'd0});

    // sin/cos quadrant fold
    assign sc_a   = r_ea & TURN_MASK;
    assign sc_sum = sc_a + EIGHTH_TURN;
    assign sc_q   = sc_sum[61:60];
    assign sc_r   = (sc_a - {2'b00, sc_q, 60'd0}) & TURN_MASK;

    assign sq_try = r_sq_res + r_sq_bit;

    assign xq = (r_c >>> 30) - $signed({32'd0, r_e});
    assign yq = $signed({{26{r_prod[67]}}, r_prod[67:30]});
    assign xi = xq <<< 26;
    assign yi = yq <<< 26;
    assign prod_radius = r_prod[67:30];

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:    if (in_acc) n_state = S_PREP;
            S_PREP:    n_state = (r_e0 == 32'd0) ? S_ANGLES : S_DIV;
            S_DIV:     if (r_dcnt == 6'd0) n_state = r_corr_phase ? S_ANGLES : S_N_UPD;
            S_ANGLES:  n_state = S_SC_INIT;
            S_SC_INIT: n_state = S_CORDIC;
            S_CORDIC:  if (r_stage == LAST_STAGE) n_state = r_vec ? S_DONE : S_SC_MAP;
            S_SC_MAP:  n_state = r_final ? S_F_MEC : S_N_MES;
            S_N_MES:   n_state = S_N_MEC;
            S_N_MEC:   n_state = S_N_P00;
            S_N_P00:   n_state = S_N_P01;
            S_N_P01:   n_state = S_N_P10;
            S_N_P10:   n_state = S_N_P11;
            S_N_P11:   n_state = S_N_F;
            S_N_F:     n_state = div_ovf ? S_N_UPD : S_DIV;
            S_N_UPD:   n_state = S_SC_INIT;
            S_F_MEC:   n_state = S_F_DEN;
            S_F_DEN:   n_state = S_F_RAD;
            S_F_RAD:   n_state = S_F_RADS;
            S_F_RADS:  n_state = (r_e == 32'd0) ? S_F_YQ : S_SQRT;
            S_SQRT:    if (r_sq_bit == 64'd1) n_state = S_F_YQ;
            S_F_YQ:    n_state = S_F_VEC;
            S_F_VEC:   n_state = (xi == 64'sd0 && yi == 64'sd0) ? S_DONE : S_CORDIC;
            S_DONE:    if (done_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: ready and multiplier operand select
    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        op_a = '0;
        op_b = '0;
        unique case (r_state)
            S_N_MES: begin
                op_a = $signed({2'b00, r_e});
                op_b = $signed({{2{s30[31]}}, s30});
            end
            S_N_MEC, S_F_MEC: begin
                op_a = $signed({2'b00, r_e});
                op_b = $signed({{2{c30[31]}}, c30});
            end
            S_N_P00: begin
                op_a = $signed({2'b00, esm[31:0]});
                op_b = $signed({2'b00, INV_TWO_PI[31:0]});
            end
            S_N_P01: begin
                op_a = $signed({2'b00, esm[31:0]});
                op_b = $signed({2'b00, INV_TWO_PI[63:32]});
            end
            S_N_P10: begin
                op_a = $signed({2'b00, esm[63:32]});
                op_b = $signed({2'b00, INV_TWO_PI[31:0]});
            end
            S_N_P11: begin
                op_a = $signed({2'b00, esm[63:32]});
                op_b = $signed({2'b00, INV_TWO_PI[63:32]});
            end
            S_F_DEN: begin
                op_a = $signed({2'b00, r_e});
                op_b = $signed({2'b00, r_e});
            end
            S_F_RAD: begin
                op_a = $signed({2'b00, r_na});
                op_b = $signed({1'b0, r_den[62:30]});
            end
            S_F_YQ: begin
                op_a = $signed({1'b0, r_sq_res[32:0]});
                op_b = $signed({{2{s30[31]}}, s30});
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_tol       <= TOL_RESET;
            r_max_iter  <= ITER_RESET;
            r_last_ea   <= '0;
            r_iter      <= '0;
            r_iter_max  <= 7'd1;
            r_stage     <= '0;
        end else begin
            r_state <= n_state;
            if (done_load) begin
                r_out_valid <= 1'b1;
                r_last_ea   <= r_ea[61:30];
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_TOLERANCE: r_tol      <= i_cfg_data;
                    CFG_MAX_ITER:  r_max_iter <= i_cfg_data[6:0];
                    default:       r_tol      <= r_tol;
                endcase
            end
            case (r_state)
                S_ANGLES: begin
                    r_iter     <= '0;
                    r_iter_max <= iters;
                end
                S_N_UPD:   r_iter  <= r_iter + 7'd1;
                S_SC_INIT: r_stage <= '0;
                S_F_VEC:   r_stage <= '0;
                S_CORDIC:  r_stage <= r_stage + 6'd1;
                default:   r_stage <= r_stage;
            endcase
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_p;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_lon  <= i_mean_longitude + i_longitude_pert;
                    r_wb   <= i_perihelion_longitude;
                    r_node <= i_node_longitude;
                    r_na   <= na_sat;
                    r_e    <= ne_sat;
                    r_e0   <= i_eccentricity;
                    r_vk   <= i_perihelion_pert;
                    r_sat  <= na_flag || ne_flag;
                    r_zdiv <= 1'b0;
                    r_conv <= 1'b0;
                end
            end
            S_PREP: begin
                r_corr_phase <= 1'b1;
                if (r_e0 == 32'd0) begin
                    // zero divisor: perihelion term saturates by sign
                    r_zdiv <= 1'b1;
                    if (r_vk[31])
                        r_quo <= 64'h0000_0000_8000_0000;
                    else if (r_vk != 32'd0)
                        r_quo <= 64'h0000_0000_7FFF_FFFF;
                    else
                        r_quo <= '0;
                end else begin
                    r_rem  <= '0;
                    r_lo   <= {mag, 32'd0};
                    r_den  <= {32'd0, r_e0};
                    r_quo  <= '0;
                    r_dcnt <= 6'd63;
                end
            end
            S_DIV: begin
                r_lo   <= {r_lo[62:0], 1'b0};
                r_dcnt <= r_dcnt - 6'd1;
                if (rem_sh >= r_den) begin
                    r_rem <= rem_sh - r_den;
                    r_quo <= {r_quo[62:0], 1'b1};
                end else begin
                    r_rem <= rem_sh;
                    r_quo <= {r_quo[62:0], 1'b0};
                end
            end
            S_ANGLES: begin
                r_m          <= r_lon - wb_new;
                r_w          <= wb_new - r_node;
                r_ea         <= {2'b00, r_last_ea, 30'd0} & AMASK;
                r_final      <= 1'b0;
                r_corr_phase <= 1'b0;
            end
            S_SC_INIT: begin
                r_x    <= CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= sc_r[61] ? $signed(sc_r - Q62_ONE) : $signed(sc_r);
                r_quad <= sc_q;
                r_vec  <= 1'b0;
            end
            S_CORDIC: begin
                if (cx_dir) begin
                    r_x <= r_x - cx_dx;
                    r_y <= r_y + cx_dy;
                    r_z <= r_z - cx_t;
                end else begin
                    r_x <= r_x + cx_dx;
                    r_y <= r_y - cx_dy;
                    r_z <= r_z + cx_t;
                end
            end
            S_SC_MAP: begin
                case (r_quad)
                    2'd0: begin r_c <= r_x;         r_s <= r_y;         end
                    2'd1: begin r_c <= -r_y;        r_s <= r_x;         end
                    2'd2: begin r_c <= -r_x;        r_s <= -r_y;        end
                    default: begin r_c <= r_y;      r_s <= -r_x;        end
                endcase
            end
            S_N_MEC: r_es  <= $signed(r_prod[63:0]);
            S_N_P00: r_den <= den_clamp;
            S_N_P01: r_mid <= {2'b00, r_prod[63:32]};
            S_N_P10: begin
                r_mid <= r_mid + {2'b00, r_prod[31:0]};
                r_acc <= {1'b0, r_prod[63:32]};
            end
            S_N_P11: begin
                r_mid <= r_mid + {2'b00, r_prod[31:0]};
                r_acc <= r_acc + {1'b0, r_prod[63:32]};
            end
            S_N_F: begin
                r_fpos <= !f[63];
                r_rem  <= {4'd0, fm[63:4]};
                r_lo   <= {fm[3:0], 60'd0};
                r_dcnt <= 6'd63;
                r_quo  <= div_ovf ? 64'hFFFF_FFFF_FFFF_FFFF : 64'd0;
            end
            S_N_UPD: begin
                r_ea    <= ea_new;
                r_conv  <= conv_now;
                r_final <= conv_now || ((r_iter + 7'd1) == r_iter_max);
            end
            S_F_DEN: r_den <= den_clamp;
            S_F_RAD: begin
                r_sq_n   <= 64'd0 - r_prod[63:0];
                r_sq_res <= (r_e == 32'd0) ? SQRT_UNITY : 64'd0;
                r_sq_bit <= SQRT_BIT0;
            end
            S_F_RADS: begin
                if (prod_radius[37:32] != 6'd0) begin
                    r_radius <= 32'hFFFF_FFFF;
                    r_sat    <= 1'b1;
                end else begin
                    r_radius <= prod_radius[31:0];
                end
            end
            S_SQRT: begin
                r_sq_bit <= r_sq_bit >> 2;
                if (r_sq_n >= sq_try) begin
                    r_sq_n   <= r_sq_n - sq_try;
                    r_sq_res <= (r_sq_res >> 1) + r_sq_bit;
                end else begin
                    r_sq_res <= r_sq_res >> 1;
                end
            end
            S_F_VEC: begin
                r_vec <= 1'b1;
                if (xi[63]) begin
                    r_x <= -xi;
                    r_y <= -yi;
                    r_z <= $signed(HALF_TURN);
                end else begin
                    r_x <= xi;
                    r_y <= yi;
                    r_z <= '0;
                end
            end
            S_DONE: begin
                if (done_load) begin
                    r_mean_anomaly   <= r_m;
                    r_arg_perihelion <= r_w;
                    r_ecc_anomaly    <= r_ea[61:30];
                    r_radius_out     <= r_radius;
                    r_true_anomaly   <= r_z[61:30];
                    r_ecc_perturbed  <= r_e;
                    r_axis_perturbed <= r_na;
                    r_status <= r_zdiv ? STAT_ZDIV :
                                (r_sat ? STAT_SAT : (r_conv ? STAT_OK : STAT_NOCONV));
                end
            end
            default: r_lo <= r_lo;
        endcase
    end

    assign o_out_valid      = r_out_valid;
    assign o_mean_anomaly   = r_mean_anomaly;
    assign o_arg_perihelion = r_arg_perihelion;
    assign o_ecc_anomaly    = r_ecc_anomaly;
    assign o_radius         = r_radius_out;
    assign o_true_anomaly   = r_true_anomaly;
    assign o_ecc_perturbed  = r_ecc_perturbed;
    assign o_axis_perturbed = r_axis_perturbed;
    assign o_status         = r_status;

    `KAS_IMPLY(a_iter_bound, i_clk, i_rst_n, r_state != S_IDLE, r_iter <= r_iter_max)
    `KAS_IMPLY(a_div_rem, i_clk, i_rst_n, r_state == S_DIV, r_rem < r_den)
    `KAS_IMPLY(a_stage_bound, i_clk, i_rst_n, r_state == S_CORDIC, r_stage <= LAST_STAGE)
    `KAS_IMPLY(a_out_from_done, i_clk, i_rst_n, $rose(r_out_valid), $past(r_state) == S_DONE)

endmodule
